>>> rtl/melody_tone_sequencer_top_defines.svh
// Assertion macros shared by the melody tone sequencer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef MELODY_TONE_SEQUENCER_TOP_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_TOP_DEFINES_SVH

// Checked at every edge once reset has been released.
`define MTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mts_pkg.sv
// Shared types, constants and note tables of the melody tone sequencer.
// No dependencies; every RTL module imports this package.
package mts_pkg;

  localparam int CLK_W       = 27;
  localparam int FREQ_W      = 11;
  localparam int DUR_W       = 9;
  localparam int GAP_W       = 5;
  localparam int NOTE_CNT    = 10;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int STEP_W      = $clog2(CLK_W);

  localparam logic [CLK_W-1:0] CLK_RESET  = CLK_W'(32000000);
  localparam logic [15:0]      PERIOD_MAX = 16'hFFFF;
  localparam logic [15:0]      PERIOD_MIN = 16'd2;

  localparam logic [1:0] CMD_UPDATE = 2'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] period_ticks;
    logic [14:0] compare_ticks;
    logic        tone_restart;
    logic        playing;
    logic [2:0]  note_position;
  } out_beat_t;

  typedef enum logic [1:0] {
    JOB_KEEP = 2'd0,
    JOB_OFF  = 2'd1,
    JOB_LOAD = 2'd2
  } job_kind_t;

  // Work handed from the front to the back: what to do with the tone.
  typedef struct packed {
    job_kind_t         kind;
    logic [FREQ_W-1:0] freq;
    logic              playing;
    logic [2:0]        note_pos;
  } job_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic [GAP_W-1:0]  gap;
  } note_t;

  typedef struct packed {
    logic  valid;
    note_t note;
  } note_lookup_t;

  function automatic note_t note_rom(input logic [3:0] idx);
    note_t n;
    case (idx)
      4'd0:    n = '{freq: 11'd523,  dur: 9'd90,  gap: 5'd25};
      4'd1:    n = '{freq: 11'd659,  dur: 9'd90,  gap: 5'd25};
      4'd2:    n = '{freq: 11'd784,  dur: 9'd120, gap: 5'd30};
      4'd3:    n = '{freq: 11'd1047, dur: 9'd220, gap: 5'd0};
      4'd4:    n = '{freq: 11'd880,  dur: 9'd80,  gap: 5'd25};
      4'd5:    n = '{freq: 11'd1175, dur: 9'd120, gap: 5'd0};
      4'd6:    n = '{freq: 11'd659,  dur: 9'd90,  gap: 5'd20};
      4'd7:    n = '{freq: 11'd784,  dur: 9'd90,  gap: 5'd20};
      4'd8:    n = '{freq: 11'd988,  dur: 9'd120, gap: 5'd25};
      4'd9:    n = '{freq: 11'd1319, dur: 9'd260, gap: 5'd0};
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] mel_base(input logic [1:0] sel);
    logic [3:0] b;
    case (sel)
      2'd2:    b = 4'd4;
      2'd3:    b = 4'd6;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] mel_count(input logic [1:0] sel);
    logic [2:0] c;
    case (sel)
      2'd1:    c = 3'd4;
      2'd2:    c = 3'd2;
      2'd3:    c = 3'd4;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // A note outside its melody, or past the table, comes back invalid.
  function automatic note_lookup_t note_lookup(input logic [1:0] sel, input logic [2:0] idx);
    note_lookup_t r;
    logic [3:0]   pos;
    pos     = mel_base(sel) + {1'b0, idx};
    r.valid = (idx < mel_count(sel)) && (pos < 4'(NOTE_CNT));
    r.note  = note_rom(pos);
    return r;
  endfunction

endpackage

>>> rtl/melody_tone_sequencer_top.sv
// Top level of the melody tone sequencer: clock register, front, job queue, back.
// Depends on mts_pkg, mts_front, mts_jobq and mts_back.
//
//   Channel  | Ports                          | Beat
//   input    | in_push, in_full, in_beat      | cmd, now_ms
//   result   | out_pop, out_empty, out_beat   | one tone status per input beat
//   config   | cfg_we, cfg_wdata              | pwm_clock_hz
//
// A play beat or a note change that loads a tone runs through the 27-step bit-serial
// period divider in the back end; other beats bypass the divider.
// The front accepts a beat every cycle while the two-entry job queue has room.
// Reset is synchronous and active low; it silences the tone and idles the melody.
// in_full rises when the queue fills; a held result stalls the back end, which can then fill the queue.
module melody_tone_sequencer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  mts_pkg::in_beat_t         in_beat,
  output logic                      out_empty,
  input  logic                      out_pop,
  output mts_pkg::out_beat_t        out_beat,
  input  logic                      cfg_we,
  input  logic [mts_pkg::CLK_W-1:0] cfg_wdata
);
  import mts_pkg::*;

  logic [CLK_W-1:0] clk_hz_r;
  logic             q_push, q_pop, q_full, q_empty;
  job_t             push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  assign in_full = q_full;

  mts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_beat (in_beat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  mts_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clk_hz    (clk_hz_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

endmodule

>>> rtl/mts_front.sv
// Front end: accepts command beats, tracks melody position and deadlines,
// and emits one tone job per beat. Depends on mts_pkg.
module mts_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  mts_pkg::in_beat_t in_beat,
  input  logic             q_full,
  output logic             q_push,
  output mts_pkg::job_t    q_job
);
  import mts_pkg::*;

  logic [1:0]   mel_sel_r, mel_sel_nxt;
  logic [2:0]   note_r, note_nxt;
  logic [31:0]  deadline_r, deadline_nxt;
  logic         gap_r, gap_nxt;
  logic         active_r, active_nxt;
  logic [31:0]  diff;
  logic         due;
  logic [2:0]   next_idx;
  note_lookup_t cur_n, next_n, play_n;

  assign q_push   = in_push && !q_full;
  assign diff     = in_beat.now_ms - deadline_r;
  assign due      = active_r && !diff[31];
  assign next_idx = note_r + 3'd1;
  assign cur_n    = note_lookup(mel_sel_r, note_r);
  assign next_n   = note_lookup(mel_sel_r, next_idx);
  assign play_n   = note_lookup(in_beat.cmd, 3'd0);

  always_comb begin
    mel_sel_nxt  = mel_sel_r;
    note_nxt     = note_r;
    deadline_nxt = deadline_r;
    gap_nxt      = gap_r;
    active_nxt   = active_r;
    q_job.kind   = JOB_KEEP;
    q_job.freq   = '0;
    if (in_beat.cmd != CMD_UPDATE) begin
      mel_sel_nxt = in_beat.cmd;
      note_nxt    = 3'd0;
      gap_nxt     = 1'b0;
      active_nxt  = 1'b1;
      if (play_n.valid) begin
        q_job.kind   = JOB_LOAD;
        q_job.freq   = play_n.note.freq;
        deadline_nxt = in_beat.now_ms + 32'(play_n.note.dur);
      end
    end else if (due) begin
      if (cur_n.valid && !gap_r && (cur_n.note.gap != '0)) begin
        q_job.kind   = JOB_OFF;
        gap_nxt      = 1'b1;
        deadline_nxt = in_beat.now_ms + 32'(cur_n.note.gap);
      end else begin
        note_nxt = next_idx;
        gap_nxt  = 1'b0;
        if ((next_idx == 3'd0) || !next_n.valid) begin
          q_job.kind = JOB_OFF;
          active_nxt = 1'b0;
        end else begin
          q_job.kind   = JOB_LOAD;
          q_job.freq   = next_n.note.freq;
          deadline_nxt = in_beat.now_ms + 32'(next_n.note.dur);
        end
      end
    end
    q_job.playing  = active_nxt;
    q_job.note_pos = note_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mel_sel_r  <= '0;
      note_r     <= '0;
      deadline_r <= '0;
      gap_r      <= 1'b0;
      active_r   <= 1'b0;
    end else if (q_push) begin
      mel_sel_r  <= mel_sel_nxt;
      note_r     <= note_nxt;
      deadline_r <= deadline_nxt;
      gap_r      <= gap_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

>>> rtl/mts_jobq.sv
// Short job queue between the front and the back of the sequencer.
// Depends on mts_pkg for the job type and depth.
module mts_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mts_pkg::job_t push_job,
  input  logic          pop,
  output mts_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import mts_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mts_back.sv
// Back end: runs tone jobs, derives the PWM period with a bit-serial divider
// and holds the result beat for the output side. Depends on mts_pkg.
`include "melody_tone_sequencer_top_defines.svh"

module mts_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mts_pkg::CLK_W-1:0] clk_hz,
  input  logic                      q_empty,
  input  mts_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output mts_pkg::out_beat_t        out_beat
);
  import mts_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } bk_state_t;

  bk_state_t         st_r, st_nxt;
  job_t              job_r;
  logic [CLK_W-1:0]  dvd_r, dvd_nxt;
  logic [FREQ_W-1:0] dsr_r;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FREQ_W:0]   trial;
  logic              qbit;
  logic [15:0]       period_hold_r, period_nxt, clamped;
  logic              out_vld_r, out_free, out_load, restart;
  out_beat_t         out_beat_r;
  job_t              res_job;

  assign out_free  = !out_vld_r || out_pop;
  assign out_empty = !out_vld_r;
  assign out_beat  = out_beat_r;

  // Restoring division: one quotient bit per cycle, quotient shifts into dvd_r.
  assign trial = {rem_r, dvd_r[CLK_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    if (dvd_r[CLK_W-1:16] != '0) begin
      clamped = PERIOD_MAX;
    end else if (dvd_r[15:0] < PERIOD_MIN) begin
      clamped = PERIOD_MIN;
    end else begin
      clamped = dvd_r[15:0];
    end
  end

  assign q_pop = (st_r == BK_IDLE) && !q_empty && ((q_job.kind == JOB_LOAD) || out_free);

  always_comb begin
    st_nxt     = st_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    out_load   = 1'b0;
    restart    = 1'b0;
    period_nxt = period_hold_r;
    res_job    = q_job;
    case (st_r)
      BK_IDLE: begin
        if (q_pop) begin
          case (q_job.kind)
            JOB_LOAD: begin
              st_nxt   = BK_DIV;
              dvd_nxt  = clk_hz;
              rem_nxt  = '0;
              step_nxt = '0;
            end
            JOB_OFF: begin
              out_load   = 1'b1;
              period_nxt = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        rem_nxt  = qbit ? FREQ_W'(trial - {1'b0, dsr_r}) : trial[FREQ_W-1:0];
        dvd_nxt  = {dvd_r[CLK_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CLK_W-1)) begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        res_job = job_r;
        if (out_free) begin
          out_load   = 1'b1;
          restart    = 1'b1;
          period_nxt = clamped;
          st_nxt     = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= BK_IDLE;
      period_hold_r <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      period_hold_r <= period_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (q_pop) begin
      job_r <= q_job;
      dsr_r <= q_job.freq;
    end
    if (out_load) begin
      out_beat_r.tone_on       <= (period_nxt != '0);
      out_beat_r.period_ticks  <= period_nxt;
      out_beat_r.compare_ticks <= period_nxt[15:1];
      out_beat_r.tone_restart  <= restart;
      out_beat_r.playing       <= res_job.playing;
      out_beat_r.note_position <= res_job.note_pos;
    end
  end

  `MTS_ASSERT(a_out_no_overwrite, out_load |-> (!out_vld_r || out_pop), "result overwritten before pop")
  `MTS_ASSERT(a_restart_period, (out_vld_r && out_beat_r.tone_restart) |-> (out_beat_r.period_ticks >= PERIOD_MIN), "restarted tone has bad period")
  `MTS_ASSERT(a_div_finishes, (st_r == BK_DIV && step_r == STEP_W'(CLK_W-1)) |=> (st_r == BK_DONE), "divider did not finish on the last step")
  `MTS_ASSERT_ALWAYS(a_pop_only_idle, q_pop |-> (st_r == BK_IDLE && !q_empty), "job taken outside idle")

endmodule

>>> bench/mts_tb_pkg.sv
`timescale 1ns / 1ps
// Command codes used by both the tone checker and the sequencer testbench top.
// Depends on mts_pkg for the update tick code.
package mts_tb_pkg;

  // The melody select register reuses these codes; the tick code means no melody.
  typedef enum logic [1:0] {
    TUNE_TICK     = mts_pkg::CMD_UPDATE,
    TUNE_STARTUP  = 2'd1,
    TUNE_ARMED    = 2'd2,
    TUNE_COMPLETE = 2'd3
  } tune_cmd_t;

endpackage

>>> bench/mts_tone_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the melody tone sequencer: tracks the note tables and deadlines,
// predicts one tone status per accepted input beat and checks the result channel.
// Depends on mts_pkg for the beat types and mts_tb_pkg for the command codes.
module mts_tone_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_full,
  input  mts_pkg::in_beat_t         in_beat,
  input  logic                      out_empty,
  input  logic                      out_pop,
  input  mts_pkg::out_beat_t        out_beat,
  input  logic                      cfg_we,
  input  logic [mts_pkg::CLK_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        results_checked
);
  import mts_pkg::*;
  import mts_tb_pkg::*;

  typedef struct packed {
    logic [15:0] hz;
    logic [15:0] tone_ms;
    logic [15:0] rest_ms;
  } score_note_t;

  logic [CLK_W-1:0] clock_hz;
  tune_cmd_t        tune_sel;
  logic [2:0]       note_pos;
  logic [31:0]      due_ms;
  logic             resting;
  logic             busy;
  logic [15:0]      load_ticks;

  out_beat_t tone_q[$];
  out_beat_t want;
  int        fails = 0;
  int        waiting = 0;
  int        results = 0;

  assign fail_count      = fails;
  assign pending         = waiting;
  assign results_checked = results;

  function automatic score_note_t score_note(input int slot);
    score_note_t n;
    case (slot)
      0:       n = '{16'd523,  16'd90,  16'd25};
      1:       n = '{16'd659,  16'd90,  16'd25};
      2:       n = '{16'd784,  16'd120, 16'd30};
      3:       n = '{16'd1047, 16'd220, 16'd0};
      4:       n = '{16'd880,  16'd80,  16'd25};
      5:       n = '{16'd1175, 16'd120, 16'd0};
      6:       n = '{16'd659,  16'd90,  16'd20};
      7:       n = '{16'd784,  16'd90,  16'd20};
      8:       n = '{16'd988,  16'd120, 16'd25};
      9:       n = '{16'd1319, 16'd260, 16'd0};
      default: n = '0;
    endcase
    return n;
  endfunction

  // Returns 1 when the note exists within the selected melody.
  function automatic bit find_note(input tune_cmd_t sel, input logic [2:0] pos,
                                   output score_note_t n);
    int first;
    int count;
    case (sel)
      TUNE_STARTUP:  begin first = 0; count = 4; end
      TUNE_ARMED:    begin first = 4; count = 2; end
      TUNE_COMPLETE: begin first = 6; count = 4; end
      default:       begin first = 0; count = 0; end
    endcase
    n = score_note(first + int'(pos));
    return (int'(pos) < count) && (first + int'(pos) < 10);
  endfunction

  function automatic logic [15:0] period_for(input logic [15:0] hz);
    int unsigned q;
    if (hz == 16'd0) return 16'hFFFF;
    q = 32'(clock_hz) / 32'(hz);
    if (q > 32'd65535) q = 32'd65535;
    if (q < 32'd2) q = 32'd2;
    return q[15:0];
  endfunction

  function automatic out_beat_t predict_tone(input in_beat_t b);
    out_beat_t   r;
    score_note_t n;
    logic        restart;
    logic [31:0] late;
    restart = 1'b0;
    late    = b.now_ms - due_ms;
    if (tune_cmd_t'(b.cmd) != TUNE_TICK) begin
      tune_sel = tune_cmd_t'(b.cmd);
      note_pos = 3'd0;
      resting  = 1'b0;
      busy     = 1'b1;
      if (find_note(tune_sel, note_pos, n)) begin
        load_ticks = period_for(n.hz);
        restart    = 1'b1;
        due_ms     = b.now_ms + 32'(n.tone_ms);
      end
    end else if (busy && !late[31]) begin
      // A sounding note with a rest goes silent first; otherwise step to the next note.
      if (find_note(tune_sel, note_pos, n) && !resting && n.rest_ms != 16'd0) begin
        load_ticks = '0;
        resting    = 1'b1;
        due_ms     = b.now_ms + 32'(n.rest_ms);
      end else begin
        note_pos = note_pos + 3'd1;
        resting  = 1'b0;
        if (note_pos != 3'd0 && find_note(tune_sel, note_pos, n)) begin
          load_ticks = period_for(n.hz);
          restart    = 1'b1;
          due_ms     = b.now_ms + 32'(n.tone_ms);
        end else begin
          load_ticks = '0;
          busy       = 1'b0;
        end
      end
    end
    r.tone_on       = (load_ticks != 16'd0);
    r.period_ticks  = load_ticks;
    r.compare_ticks = load_ticks[15:1];
    r.tone_restart  = restart;
    r.playing       = busy;
    r.note_position = note_pos;
    return r;
  endfunction

  task automatic log_fault(input string why, input out_beat_t exp_beat);
    fails++;
    if (fails <= 10) begin
      $display("[%0t] %s (result %0d)", $time, why, results);
      $display("  expected on=%0b period=%0d cmp=%0d restart=%0b playing=%0b note=%0d",
               exp_beat.tone_on, exp_beat.period_ticks, exp_beat.compare_ticks,
               exp_beat.tone_restart, exp_beat.playing, exp_beat.note_position);
      $display("  actual   on=%0b period=%0d cmp=%0d restart=%0b playing=%0b note=%0d",
               out_beat.tone_on, out_beat.period_ticks, out_beat.compare_ticks,
               out_beat.tone_restart, out_beat.playing, out_beat.note_position);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_hz   = 27'd32_000_000;
      tune_sel   = TUNE_TICK;
      note_pos   = 3'd0;
      due_ms     = '0;
      resting    = 1'b0;
      busy       = 1'b0;
      load_ticks = '0;
      tone_q.delete();
    end else begin
      // Results are matched before this edge's input beat is queued.
      if (out_pop && !out_empty) begin
        results++;
        if (tone_q.size() == 0) begin
          log_fault("result beat with nothing expected", '0);
        end else begin
          want = tone_q.pop_front();
          if (out_beat !== want) log_fault("tone status mismatch", want);
        end
      end
      if (cfg_we) clock_hz = cfg_wdata;
      if (in_push && !in_full) tone_q.push_back(predict_tone(in_beat));
    end
    waiting = tone_q.size();
  end

endmodule

>>> bench/tb_melody_tone_sequencer_top.sv
`timescale 1ns / 1ps
// Testbench top for melody_tone_sequencer_top: clock, reset, beat stimulus and verdict.
// Depends on mts_pkg, mts_tb_pkg, mts_tone_checker and the sequencer RTL.
module tb_melody_tone_sequencer_top;
  import mts_pkg::*;
  import mts_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 145;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 64;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  in_beat_t         in_beat = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  out_beat_t        out_beat;
  logic             cfg_we = 1'b0;
  logic [CLK_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int results_checked;
  int cycles = 0;
  int beats_sent = 0;
  int settings_used = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit hold_req = 1'b0;

  melody_tone_sequencer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_beat   (in_beat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mts_tone_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_beat         (in_beat),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_beat        (out_beat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               CYCLE_LIMIT, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one beat after a random gap and returns once it has been taken.
  task automatic send_beat(input tune_cmd_t c, input logic [31:0] stamp);
    int idle;
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
    idle = quiet_tx ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (idle > 0) begin
      in_push <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_beat.cmd    <= c;
    in_beat.now_ms <= stamp;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  task automatic end_phase();
    @(negedge clk);
    in_push <= 1'b0;
    wait (pending == 0);
  endtask

  // Result side: random pop gaps, quiet stretches, and one long hold on request.
  initial begin : result_drain
    int idle;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
      idle = quiet_rx ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        idle     = idle + LONG_HOLD;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (idle > 0) begin
        out_pop <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  initial begin : stimulus
    logic [CLK_W-1:0] clock_plan [8];
    logic [31:0]      stamp;
    int               goal;
    int               ticks;
    int               roll;
    clock_plan = '{27'd0, 27'd1, 27'h7FF_FFFF, 27'd80_000_000, 27'd34_274_805,
                   27'd3000, 27'd32_000_000, 27'd1};
    clock_plan[7] = CLK_W'($urandom_range(1, 80_000_000));
    wait (rst_n === 1'b1);

    // Directed walk through the tunes at the reset clock rate.
    send_beat(TUNE_TICK, 32'd0);
    send_beat(TUNE_STARTUP, 32'd1000);
    send_beat(TUNE_TICK, 32'd1089);
    send_beat(TUNE_TICK, 32'd1090);
    send_beat(TUNE_TICK, 32'd1115);
    send_beat(TUNE_ARMED, 32'd1150);
    send_beat(TUNE_TICK, 32'd1230);
    send_beat(TUNE_TICK, 32'd1255);
    // The armed tune's last note has no rest, so this tick ends the tune.
    send_beat(TUNE_TICK, 32'd1375);
    send_beat(TUNE_TICK, 32'd1500);
    // The deadline wraps past zero; half a range ahead must still read as early.
    send_beat(TUNE_COMPLETE, 32'hFFFF_FFC0);
    send_beat(TUNE_TICK, 32'h8000_001A);
    send_beat(TUNE_TICK, 32'hFFFF_FFFF);
    send_beat(TUNE_TICK, 32'h0000_001A);
    send_beat(TUNE_TICK, 32'h0000_002E);
    send_beat(TUNE_TICK, 32'h0000_0088);
    send_beat(TUNE_TICK, 32'h0000_009C);
    send_beat(TUNE_TICK, 32'h0000_0114);
    send_beat(TUNE_TICK, 32'h0000_012D);
    send_beat(TUNE_TICK, 32'h0000_0231);
    send_beat(TUNE_STARTUP, 32'hFFFF_FFFF);
    send_beat(TUNE_TICK, 32'hFFFF_FFFF);
    end_phase();

    for (int ph = 0; ph < 8; ph++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= clock_plan[ph];
      @(negedge clk);
      cfg_we <= 1'b0;
      settings_used++;
      if (ph == 1) hold_req = 1'b1;
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          // A tune started at a random time, then ticks that mostly move forward.
          stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                              : $urandom();
          send_beat(tune_cmd_t'($urandom_range(1, 3)), stamp);
          ticks = $urandom_range(8, 40);
          repeat (ticks) begin
            roll = $urandom_range(0, 19);
            if (roll < 14) stamp = stamp + $urandom_range(0, 45);
            else if (roll < 16) stamp = stamp + $urandom_range(100, 300);
            else if (roll == 16) stamp = stamp - $urandom_range(1, 50);
            else if (roll == 17) stamp = stamp + 32'h7FFF_FFF0 + $urandom_range(0, 31);
            else if (roll == 18) send_beat(tune_cmd_t'($urandom_range(1, 3)), stamp);
            else stamp = $urandom();
            send_beat(TUNE_TICK, stamp);
          end
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(tune_cmd_t'($urandom_range(0, 3)), $urandom());
        end
      end
      end_phase();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d beats: directed tune walks, wrapped deadlines, random tunes and noise,",
             beats_sent);
    $display("under %0d clock settings; %0d results checked, %0d mismatches.",
             settings_used, results_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> melody_tone_sequencer_top.f
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_front.sv
rtl/mts_jobq.sv
rtl/mts_back.sv
rtl/melody_tone_sequencer_top.sv
bench/mts_tb_pkg.sv
bench/mts_tone_checker.sv
bench/tb_melody_tone_sequencer_top.sv
